[design/stks_pkg.sv]
// shared types and helpers for the streaming top-k selector
`timescale 1ns / 1ps
package stks_pkg;

    localparam int SCORE_W = 32;
    localparam int POS_W   = 16;
    localparam int KCNT_W  = 5;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [POS_W-1:0]   pos;
    } entry_t;

    typedef enum logic [0:0] {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    function automatic logic [SCORE_W-1:0] order_key(input logic [SCORE_W-1:0] bits);
        logic [SCORE_W-1:0] b;
        b = bits;
        if (b == {1'b1, {(SCORE_W-1){1'b0}}})
        begin
            b = '0;
        end
        if (b[SCORE_W-1])
        begin
            order_key = ~b;
        end
        else
        begin
            order_key = b | {1'b1, {(SCORE_W-1){1'b0}}};
        end
    endfunction

endpackage

[design/stks_if.sv]
// valid/ready stream interfaces for the selector
`timescale 1ns / 1ps
interface stks_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] score;
    logic        last_score;
    modport source (output valid, output score, output last_score, input ready);
    modport sink (input valid, input score, input last_score, output ready);
endinterface

interface stks_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] rank_index;
    logic [31:0] score_value;
    logic        last_result;
    logic        position_overflow;
    modport source (output valid, output rank_index, output score_value,
                    output last_result, output position_overflow, input ready);
    modport sink (input valid, input rank_index, input score_value,
                  input last_result, input position_overflow, output ready);
endinterface

[design/streaming_top_k_select.sv]
// streaming top-k selector top level
//
// in_ch carries one score per transfer with last_score on the final one.
// scores are inserted into a chain of LIST_DEPTH compare-and-shift cells,
// one item per cycle while a stream is being collected.
// the transfer with last_score set is inserted like the others; after it
// the kept entries leave on out_ch largest first, one per cycle while
// out_ch is ready, with last_result on the final one. in_ch is held off
// during that drain.
// the first result is offered in the cycle after the last input transfer.
// keep_count (1..LIST_DEPTH, reset 16) is written through cfg_we/cfg_data.
// equal scores keep the earlier position first; positions saturate at
// min(MAX_STREAM-1, 65535) and set position_overflow on the whole list.
// reset empties the list and clears the position counter.
// a stalled receiver holds the current result and the drain waits.
`timescale 1ns / 1ps
module streaming_top_k_select #(
    parameter int LIST_DEPTH = 16,
    parameter longint MAX_STREAM = 65536
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [stks_pkg::KCNT_W-1:0] cfg_data,
    stks_in_if.sink                  in_ch,
    stks_out_if.source               out_ch
);
    import stks_pkg::*;

    localparam longint TOP_L = (MAX_STREAM - 1 > 65535) ? 65535 : MAX_STREAM - 1;
    localparam logic [POS_W-1:0] TOP_POS = POS_W'(TOP_L);

    state_t state_reg;
    state_t state_next;
    logic [KCNT_W-1:0] keep_reg;
    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic              top_used_reg;
    logic              top_used_next;
    logic              ovf_reg;
    logic              ovf_next;

    entry_t cell_entry [LIST_DEPTH];
    logic   cell_valid [LIST_DEPTH];
    logic   cell_takes [LIST_DEPTH];
    logic   in_range   [LIST_DEPTH];

    logic   accept;
    logic   insert;
    logic   drain;
    logic   clear;
    entry_t new_entry;
    logic [KCNT_W-1:0] lim;

    always_comb
    begin
        lim = keep_reg;
        if (lim < KCNT_W'(1))
        begin
            lim = KCNT_W'(1);
        end
        if (32'(lim) > LIST_DEPTH)
        begin
            lim = KCNT_W'(LIST_DEPTH);
        end
    end

    assign in_ch.ready = (state_reg == ST_COLLECT);
    assign accept = in_ch.valid && in_ch.ready;
    assign insert = accept;
    assign drain  = (state_reg == ST_DRAIN) && out_ch.ready && cell_valid[0];
    assign clear  = drain && !(LIST_DEPTH > 1 && cell_valid[LIST_DEPTH > 1 ? 1 : 0])
                    && 1'b0;
    assign new_entry.score = in_ch.score;
    assign new_entry.pos   = top_used_reg ? TOP_POS : pos_reg;

    genvar g;
    generate
        for (g = 0; g < LIST_DEPTH; g++)
        begin : g_cell
            assign in_range[g] = (32'(g) < 32'(lim));
            if (g == 0)
            begin : g_head
                stks_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .insert(insert), .drain(drain),
                    .clear(clear), .in_range(in_range[g]), .new_entry(new_entry),
                    .prev_entry(new_entry), .prev_valid(1'b1), .prev_takes(1'b0),
                    .below_entry(LIST_DEPTH > 1 ? cell_entry[LIST_DEPTH > 1 ? 1 : 0]
                                                : cell_entry[0]),
                    .below_valid(LIST_DEPTH > 1 ? cell_valid[LIST_DEPTH > 1 ? 1 : 0]
                                                : 1'b0),
                    .entry(cell_entry[g]), .valid(cell_valid[g]), .takes(cell_takes[g])
                );
            end
            else
            begin : g_body
                stks_cell u_cell (
                    .clk(clk), .rst_n(rst_n), .insert(insert), .drain(drain),
                    .clear(clear), .in_range(in_range[g]), .new_entry(new_entry),
                    .prev_entry(cell_entry[g-1]), .prev_valid(cell_valid[g-1]),
                    .prev_takes(cell_takes[g-1]),
                    .below_entry(g + 1 < LIST_DEPTH ? cell_entry[g + 1 < LIST_DEPTH ? g + 1 : g]
                                                    : cell_entry[g]),
                    .below_valid(g + 1 < LIST_DEPTH ? cell_valid[g + 1 < LIST_DEPTH ? g + 1 : g]
                                                    : 1'b0),
                    .entry(cell_entry[g]), .valid(cell_valid[g]), .takes(cell_takes[g])
                );
            end
        end
    endgenerate

    // position counter and overflow tracking
    always_comb
    begin
        pos_next      = pos_reg;
        top_used_next = top_used_reg;
        ovf_next      = ovf_reg;
        if (accept)
        begin
            if (top_used_reg)
            begin
                ovf_next = 1'b1;
            end
            else if (pos_reg >= TOP_POS)
            begin
                top_used_next = 1'b1;
                pos_next      = TOP_POS;
            end
            else
            begin
                pos_next = pos_reg + POS_W'(1);
            end
        end
        if (state_reg == ST_DRAIN && drain && !cell_valid[LIST_DEPTH > 1 ? 1 : 0])
        begin
            pos_next      = '0;
            top_used_next = 1'b0;
            ovf_next      = 1'b0;
        end
        if (LIST_DEPTH == 1 && drain)
        begin
            pos_next      = '0;
            top_used_next = 1'b0;
            ovf_next      = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (accept && in_ch.last_score)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (drain && (LIST_DEPTH == 1 || !cell_valid[LIST_DEPTH > 1 ? 1 : 0]))
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        out_ch.valid             = (state_reg == ST_DRAIN) && cell_valid[0];
        out_ch.rank_index        = cell_entry[0].pos;
        out_ch.score_value       = cell_entry[0].score;
        out_ch.last_result       = (LIST_DEPTH == 1) || !cell_valid[LIST_DEPTH > 1 ? 1 : 0];
        out_ch.position_overflow = ovf_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_COLLECT;
            keep_reg     <= KCNT_W'(16);
            pos_reg      <= '0;
            top_used_reg <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            top_used_reg <= top_used_next;
            ovf_reg      <= ovf_next;
            if (cfg_we)
            begin
                keep_reg <= cfg_data;
            end
        end
    end
endmodule

[design/stks_cell.sv]
// one slot of the sorted list: compare-and-shift insert, shift-up drain
`timescale 1ns / 1ps
module stks_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              insert,
    input  logic              drain,
    input  logic              clear,
    input  logic              in_range,
    input  stks_pkg::entry_t  new_entry,
    input  stks_pkg::entry_t  prev_entry,
    input  logic              prev_valid,
    input  logic              prev_takes,
    input  stks_pkg::entry_t  below_entry,
    input  logic              below_valid,
    output stks_pkg::entry_t  entry,
    output logic              valid,
    output logic              takes
);
    import stks_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;
    logic   valid_reg;
    logic   valid_next;

    // new entry belongs here or above when it beats the held one (or slot empty)
    assign takes = in_range && (!valid_reg ||
                   (order_key(new_entry.score) > order_key(entry_reg.score)));

    always_comb
    begin
        entry_next = entry_reg;
        // the list is cut to the current limit only when a score goes in
        valid_next = valid_reg && (in_range || !insert);
        if (clear)
        begin
            valid_next = 1'b0;
        end
        else if (drain)
        begin
            entry_next = below_entry;
            valid_next = below_valid;
        end
        else if (insert && in_range)
        begin
            if (prev_takes)
            begin
                entry_next = prev_entry;
                valid_next = prev_valid;
            end
            else if (takes)
            begin
                entry_next = new_entry;
                valid_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign valid = valid_reg;
endmodule

[tb/stks_checker.sv]
// checker: predicts the selector's ranked lists and compares every output transfer
`timescale 1ns / 1ps
module stks_checker (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [4:0] cfg_data,
    stks_in_if.sink    in_ch,
    stks_out_if.sink   out_ch,
    output int         fail_count,
    output int         pending
);
    typedef struct {
        logic [15:0] rank_index;
        logic [31:0] score_value;
        logic        last_result;
        logic        position_overflow;
    } rank_t;

    localparam int DEPTH = 16;
    localparam logic [15:0] TOP_POS = 16'hFFFF;

    rank_t       ranked_q[$];
    logic [31:0] top_scores[DEPTH];
    logic [15:0] top_pos[DEPTH];
    int          top_cnt;
    logic [15:0] pos_next;
    logic        ovf;
    logic        top_taken;
    logic [4:0]  keep_reg;

    function automatic logic [31:0] rank_key(logic [31:0] b);
        if (b == 32'h8000_0000)
            b = '0;
        return b[31] ? ~b : (b | 32'h8000_0000);
    endfunction

    function automatic int keep_limit();
        int l;
        l = keep_reg;
        if (l < 1)
            l = 1;
        if (l > DEPTH)
            l = DEPTH;
        return l;
    endfunction

    task automatic insert_score(logic [31:0] s, logic [15:0] p);
        int lim;
        int idx;
        int n;
        lim = keep_limit();
        idx = 0;
        if (top_cnt > lim)
            top_cnt = lim;
        n = top_cnt;
        while (idx < n && rank_key(top_scores[idx]) >= rank_key(s))
            idx++;
        if (n < lim)
            n++;
        else if (idx >= lim)
            return;
        for (int i = n - 1; i > idx; i--)
        begin
            top_scores[i] = top_scores[i-1];
            top_pos[i] = top_pos[i-1];
        end
        top_scores[idx] = s;
        top_pos[idx] = p;
        top_cnt = n;
    endtask

    task automatic take_score(logic [31:0] s, logic last);
        logic [15:0] p;
        rank_t r;
        if (top_taken)
        begin
            p = TOP_POS;
            ovf = 1'b1;
        end
        else
        begin
            p = pos_next;
            if (pos_next == TOP_POS)
                top_taken = 1'b1;
            else
                pos_next++;
        end
        insert_score(s, p);
        if (last)
        begin
            for (int i = 0; i < top_cnt; i++)
            begin
                r.rank_index = top_pos[i];
                r.score_value = top_scores[i];
                r.last_result = (i == top_cnt - 1);
                r.position_overflow = ovf;
                ranked_q.push_back(r);
            end
            top_cnt = 0;
            pos_next = '0;
            ovf = 1'b0;
            top_taken = 1'b0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rank_t e;
        if (!rst_n)
        begin
            ranked_q.delete();
            top_cnt = 0;
            pos_next = '0;
            ovf = 1'b0;
            top_taken = 1'b0;
            keep_reg = 5'd16;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (ranked_q.size() == 0)
                begin
                    $error("unexpected output transfer idx=%0d score=%h",
                           out_ch.rank_index, out_ch.score_value);
                    fail_count++;
                end
                else
                begin
                    e = ranked_q.pop_front();
                    if (out_ch.rank_index !== e.rank_index)
                    begin
                        $error("rank_index exp %0d got %0d", e.rank_index, out_ch.rank_index);
                        fail_count++;
                    end
                    if (out_ch.score_value !== e.score_value)
                    begin
                        $error("score_value exp %h got %h", e.score_value,
                               out_ch.score_value);
                        fail_count++;
                    end
                    if (out_ch.last_result !== e.last_result)
                    begin
                        $error("last_result exp %b got %b", e.last_result,
                               out_ch.last_result);
                        fail_count++;
                    end
                    if (out_ch.position_overflow !== e.position_overflow)
                    begin
                        $error("position_overflow exp %b got %b", e.position_overflow,
                               out_ch.position_overflow);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
                keep_reg = cfg_data;
            if (in_ch.valid && in_ch.ready)
                take_score(in_ch.score, in_ch.last_score);
            pending = ranked_q.size();
        end
    end
endmodule

[tb/tb_streaming_top_k_select.sv]
// testbench top: drives score streams and keep_count settings, reports the verdict
`timescale 1ns / 1ps
module tb_streaming_top_k_select;
    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic [4:0] cfg_data = 5'd16;
    int         fail_count;
    int         pending;
    logic       calm = 1'b0;
    logic       hold_off = 1'b0;

    stks_in_if  in_ch ();
    stks_out_if out_ch ();

    streaming_top_k_select dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg_we (cfg_we),
        .cfg_data(cfg_data),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    stks_checker chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch.sink),
        .out_ch    (out_ch.sink),
        .fail_count(fail_count),
        .pending   (pending)
    );

    always #5 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.score = '0;
        in_ch.last_score = 1'b0;
        out_ch.ready = 1'b0;
    end

    // receiver: random stall bursts, plus one long hold-off
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                out_ch.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0)
            begin
                gap = $urandom_range(1, 4);
                out_ch.ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
            begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    function automatic logic [31:0] pick_score();
        case ($urandom_range(0, 9))
            0: return 32'h0000_0000;
            1: return 32'h8000_0000;
            2: return 32'h7F80_0000;
            3: return 32'hFF80_0000;
            4: return 32'h3F80_0000;
            5: return {$urandom_range(0, 1) == 1, 31'h3F80_0000};
            default: return $urandom;
        endcase
    endfunction

    task automatic send_score(logic [31:0] s, logic last);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.score <= s;
        in_ch.last_score <= last;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic go_idle(logic [4:0] k);
        in_ch.valid <= 1'b0;
        in_ch.last_score <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_data <= k;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_stream(int len);
        for (int i = 0; i < len; i++)
            send_score(pick_score(), i == len - 1);
    endtask

    initial
    begin
        int sent;
        int len;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        // directed: extremes, ties, signed zeros, short stream
        send_score(32'h0000_0000, 1'b0);
        send_score(32'h8000_0000, 1'b0);
        send_score(32'h7F80_0000, 1'b0);
        send_score(32'hFF80_0000, 1'b0);
        send_score(32'hFFFF_FFFF, 1'b0);
        send_score(32'h7FFF_FFFF, 1'b0);
        send_score(32'h3F80_0000, 1'b0);
        send_score(32'h3F80_0000, 1'b1);
        send_score(32'h4000_0000, 1'b1);
        go_idle(5'd1);
        send_stream(6);
        go_idle(5'd0);
        send_stream(4);
        go_idle(5'd31);
        send_stream(20);
        go_idle(5'd3);
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (60) @(negedge clk);
                hold_off = 1'b0;
            end
            begin
                send_stream(5);
                send_stream(5);
            end
        join
        go_idle(5'd16);
        // position saturation: 65538 items, no idling
        calm = 1'b1;
        for (int i = 0; i < 65538; i++)
        begin
            in_ch.valid <= 1'b1;
            in_ch.score <= $urandom;
            in_ch.last_score <= (i == 65537);
            @(posedge clk);
            while (!in_ch.ready)
                @(posedge clk);
            @(negedge clk);
        end
        calm = 1'b0;
        sent = 0;
        while (sent < 120)
        begin
            go_idle(5'($urandom_range(1, 16)));
            len = $urandom_range(1, 24);
            // keep count changed mid-stream
            if ($urandom_range(0, 3) == 0)
            begin
                send_stream(0);
                for (int i = 0; i < len; i++)
                begin
                    if (i == len / 2)
                    begin
                        in_ch.valid <= 1'b0;
                        @(negedge clk);
                        cfg_we <= 1'b1;
                        cfg_data <= 5'($urandom_range(1, 16));
                        @(negedge clk);
                        cfg_we <= 1'b0;
                    end
                    send_score(pick_score(), i == len - 1);
                end
            end
            else
            begin
                send_stream(len);
            end
            sent += len;
            if (sent > 90)
                calm = 1'b1;
        end
        in_ch.valid <= 1'b0;
        in_ch.last_score <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("tb_streaming_top_k_select: clean");
        else
            $display("tb_streaming_top_k_select: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("tb_streaming_top_k_select: errors");
        $finish;
    end
endmodule
